// File: rtl/core/phws_pkg.sv
// ============================================================================
// phws_pkg
// Shared types and constants for the power history window statistics core:
// request and response words, sequencer states and derived widths.
// ============================================================================
`default_nettype none

package phws_pkg;

   // History ring geometry
   localparam int HISTORY_DEPTH = 3600;
   localparam int SAMPLE_BITS   = 24;
   localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

   // Field widths of the request and response words
   localparam int INTERVAL_W = 12;
   localparam int WINDOW_W   = 16;
   localparam int TOTAL_W    = 48;
   localparam int AVG_W      = 36;
   localparam int AGE_W      = 12;
   localparam int USED_W     = 12;
   localparam int PROD_W     = SAMPLE_BITS + INTERVAL_W;
   localparam int DIV_CNT_W  = $clog2(TOTAL_W);

   // Request kinds
   localparam logic KIND_PUSH  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Response status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [SAMPLE_BITS-1:0] sample_power;
      logic [WINDOW_W-1:0]    window_length;
   } phws_req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]     window_total;
      logic [AVG_W-1:0]       window_average;
      logic [SAMPLE_BITS-1:0] window_minimum;
      logic [AGE_W-1:0]       minimum_age;
      logic [TOTAL_W-1:0]     excess_above_average;
      logic [USED_W-1:0]      samples_used;
      logic                   status;
   } phws_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS1,
      ST_DIVIDE,
      ST_PASS2,
      ST_REPLY
   } phws_state_type;

endpackage

`default_nettype wire

// File: rtl/core/power_history_window_stats_core.sv
// ============================================================================
// power_history_window_stats_core
// History ring of power samples with windowed statistics computed by one
// shared read/accumulate path under a small sequencer.
// ============================================================================
//
// Usage:
//   Request word (req_word) is taken on a clock edge where start is high and
//   busy is low. A push (kind 0) writes the sample into the ring in that
//   same cycle and busy stays low, so pushes go back to back, one per cycle.
//   A query (kind 1) raises busy until its reply has been issued. The reply
//   word is on rsp_word while rsp_strobe is high for a single cycle; the
//   receiver has no way to hold it off and must take it then.
//   A query, with N = samples used (window clamped to stored count), runs
//     a first pass over N ring samples (total and minimum),
//     a bit-serial divide of total by N,
//     a second pass over the same samples (excess over the average),
//     and then loads the reply.
//   An empty store or zero window replies with status error. The single
//   read port of the history RAM sets the pass length. sample_interval is
//   written through csr_write_enable/csr_write_data; the user must write it
//   only while idle, the block does not enforce it. Reset empties the ring
//   (count and pointer to zero), sets the interval to one, RAM not cleared.
// ============================================================================
`default_nettype none

module power_history_window_stats_core
   import phws_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire phws_req_type          req_word,
   output logic                       rsp_strobe,
   output phws_rsp_type               rsp_word,
   input  wire logic                  csr_write_enable,
   input  wire logic [INTERVAL_W-1:0] csr_write_data
);

   // ------------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------------
   phws_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] hist_mem [HISTORY_DEPTH];

   logic [ADDR_W-1:0]      newest_ff, newest_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [INTERVAL_W-1:0]  interval_ff;
   logic [CNT_W-1:0]       used_ff;
   logic                   err_ff;

   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [CNT_W-1:0]       issue_cnt_ff, issue_cnt_in;
   logic                   rd_vld_ff;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [CNT_W-1:0]       rd_age_ff;
   logic                   prod_vld_ff;
   logic [PROD_W-1:0]      prod_ff;

   logic [TOTAL_W-1:0]     total_ff;
   logic [SAMPLE_BITS-1:0] min_ff;
   logic [CNT_W-1:0]       min_age_ff;
   logic [TOTAL_W-1:0]     excess_ff;

   logic [TOTAL_W-1:0]     div_ff, div_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic [CNT_W:0]         rem_shift;
   logic                   quot_bit;

   phws_rsp_type           rsp_ff, rsp_in;
   logic                   strobe_ff;

   logic                   accept;
   logic                   accept_push;
   logic                   accept_query;
   logic                   query_err;
   logic [CNT_W-1:0]       used_calc;
   logic                   issue_done;
   logic                   issue_en;
   logic                   pass_init;
   logic                   pass1_end;
   logic                   div_last;
   logic [AVG_W-1:0]       avg_word;

   // ------------------------------------------------------------------------
   // Request decode and window clamp
   // ------------------------------------------------------------------------
   assign accept       = start && !busy;
   assign accept_push  = accept && (req_word.kind == KIND_PUSH);
   assign accept_query = accept && (req_word.kind == KIND_QUERY);
   assign query_err    = (count_ff == '0) || (req_word.window_length == '0);
   assign used_calc    = (req_word.window_length > WINDOW_W'(count_ff)) ?
                         count_ff : CNT_W'(req_word.window_length);

   assign issue_done = (issue_cnt_ff == used_ff);
   assign avg_word   = div_ff[AVG_W-1:0];

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_query) begin
               state_in = query_err ? ST_REPLY : ST_PASS1;
            end
         end
         ST_PASS1: begin
            if (issue_done && !rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_cnt_ff == '0) begin
               state_in = ST_PASS2;
            end
         end
         ST_PASS2: begin
            if (issue_done && !rd_vld_ff) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer outputs
   // ------------------------------------------------------------------------
   always_comb begin
      busy      = 1'b1;
      issue_en  = 1'b0;
      pass1_end = 1'b0;
      div_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   busy = 1'b0;
         ST_PASS1: begin
            issue_en  = !issue_done;
            pass1_end = issue_done && !rd_vld_ff && !prod_vld_ff;
         end
         ST_DIVIDE: div_last = (div_cnt_ff == '0);
         ST_PASS2:  issue_en = !issue_done;
         ST_REPLY:  busy = 1'b1;
         default:   busy = 1'b1;
      endcase
      pass_init = (accept_query && !query_err) || div_last;
   end

   // ------------------------------------------------------------------------
   // Ring pointer, fill count and read address walk
   // ------------------------------------------------------------------------
   always_comb begin
      newest_in = (newest_ff == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : newest_ff + 1'b1;
      count_in  = (count_ff < CNT_W'(HISTORY_DEPTH)) ? count_ff + 1'b1 : count_ff;

      addr_in      = addr_ff;
      issue_cnt_in = issue_cnt_ff;
      if (pass_init) begin
         addr_in      = newest_ff;
         issue_cnt_in = '0;
      end else if (issue_en) begin
         addr_in      = (addr_ff == '0) ? ADDR_W'(HISTORY_DEPTH - 1) : addr_ff - 1'b1;
         issue_cnt_in = issue_cnt_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Restoring divide step, one quotient bit per cycle
   // ------------------------------------------------------------------------
   always_comb begin
      rem_shift = {rem_ff, div_ff[TOTAL_W-1]};
      quot_bit  = (rem_shift >= {1'b0, used_ff});
      rem_in    = quot_bit ? CNT_W'(rem_shift - {1'b0, used_ff}) : rem_shift[CNT_W-1:0];
      div_in    = {div_ff[TOTAL_W-2:0], quot_bit};
   end

   // ------------------------------------------------------------------------
   // Reply word
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_in = '0;
      if (err_ff) begin
         rsp_in.status = STATUS_ERROR;
      end else begin
         rsp_in.window_total         = total_ff;
         rsp_in.window_average       = avg_word;
         rsp_in.window_minimum       = min_ff;
         rsp_in.minimum_age          = AGE_W'(min_age_ff);
         rsp_in.excess_above_average = excess_ff;
         rsp_in.samples_used         = USED_W'(used_ff);
         rsp_in.status               = STATUS_OK;
      end
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         newest_ff    <= '0;
         count_ff     <= '0;
         interval_ff  <= INTERVAL_W'(1);
         issue_cnt_ff <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_vld_ff    <= issue_en;
         prod_vld_ff  <= rd_vld_ff && (state_ff == ST_PASS1);
         strobe_ff    <= (state_ff == ST_REPLY);
         if (accept_push) begin
            newest_ff <= newest_in;
            count_ff  <= count_in;
         end
         if (csr_write_enable) begin
            interval_ff <= csr_write_data;
         end
      end
   end

   // ------------------------------------------------------------------------
   // History RAM: one write port, one registered read port
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept_push) begin
         hist_mem[newest_in] <= req_word.sample_power;
      end
      if (issue_en) begin
         rd_data_ff <= hist_mem[addr_ff];
      end
   end

   // ------------------------------------------------------------------------
   // Datapath: read walk, multiply, accumulate, min search, divide, excess
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      rd_age_ff <= issue_cnt_ff;

      if (accept_query) begin
         used_ff   <= used_calc;
         err_ff    <= query_err;
         total_ff  <= '0;
         excess_ff <= '0;
      end

      // pass one: weight each sample and track the first minimum
      if (rd_vld_ff && (state_ff == ST_PASS1)) begin
         prod_ff <= PROD_W'(rd_data_ff) * PROD_W'(interval_ff);
         if ((rd_age_ff == '0) || (rd_data_ff < min_ff)) begin
            min_ff     <= rd_data_ff;
            min_age_ff <= rd_age_ff;
         end
      end
      if (prod_vld_ff) begin
         total_ff <= total_ff + TOTAL_W'(prod_ff);
      end

      // divide total by samples used; quotient replaces dividend
      if (pass1_end) begin
         div_ff     <= total_ff;
         rem_ff     <= '0;
         div_cnt_ff <= DIV_CNT_W'(TOTAL_W - 1);
      end else if (state_ff == ST_DIVIDE) begin
         div_ff     <= div_in;
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end

      // pass two: sum of excess over the average
      if (rd_vld_ff && (state_ff == ST_PASS2)) begin
         if (AVG_W'(rd_data_ff) > avg_word) begin
            excess_ff <= excess_ff + TOTAL_W'(AVG_W'(rd_data_ff) - avg_word);
         end
      end

      if (state_ff == ST_REPLY) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_strobe_after_reply : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_REPLY))
      else $error("reply strobe without reply state");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("stored count exceeds ring depth");

   a_issue_bounded : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PASS1) || (state_ff == ST_PASS2)) |-> (issue_cnt_ff <= used_ff))
      else $error("read walk ran past the window");

   a_push_no_reply : assert property (@(posedge clock) disable iff (reset)
      accept_push |=> !rsp_strobe)
      else $error("push produced a reply");

endmodule

`default_nettype wire
